### sv/kpm_pkg.sv
// Shared types, constants and helper functions for the keyword prefix matcher.
// Used by the controller, the datapath, the top level and the checker.
`default_nettype none
package kpm_pkg;

	// Table geometry.
	localparam int MAX_ENTRIES = 16;
	localparam int MAX_WIDTH   = 16;
	localparam int ENT_W       = $clog2(MAX_ENTRIES);
	localparam int POS_W       = $clog2(MAX_WIDTH);
	localparam int ADDR_W      = ENT_W + POS_W;
	localparam int MEM_DEPTH   = MAX_ENTRIES * MAX_WIDTH;
	localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
	localparam int WCNT_W      = $clog2(MAX_WIDTH + 1);
	localparam int QLEN_W      = 5;
	localparam int SUM_W       = QLEN_W + 1;

	// Configuration port.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 5;
	localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_ELEMENT_WIDTH = CFG_IDX_W'(1);
	localparam logic [CFG_DATA_W-1:0] RST_ENTRY_COUNT   = CFG_DATA_W'(0);
	localparam logic [CFG_DATA_W-1:0] RST_ELEMENT_WIDTH = CFG_DATA_W'(8);

	// Item function codes.
	localparam logic FN_LOAD  = 1'b0;
	localparam logic FN_QUERY = 1'b1;

	// Result status codes.
	localparam logic [1:0] ST_PREFIX = 2'd0;
	localparam logic [1:0] ST_EXACT  = 2'd1;
	localparam logic [1:0] ST_NONE   = 2'd2;
	localparam logic [1:0] ST_AMBIG  = 2'd3;

	// Characters.
	localparam logic [7:0] CH_SPACE = 8'd32;
	localparam logic [7:0] CH_NUL   = 8'd0;
	localparam logic [7:0] CH_TAB   = 8'd9;
	localparam logic [7:0] CH_CR    = 8'd13;

	typedef struct packed {
		logic       func;
		logic [3:0] entry;
		logic [3:0] position;
		logic [7:0] char_value;
		logic       last;
	} kpm_in_t;

	typedef struct packed {
		logic [1:0] status;
		logic [3:0] match_index;
	} kpm_out_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic query;
		logic scan;
		logic eval;
		logic publish;
	} kpm_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_query;
		logic is_last;
		logic need_cmp;
		logic scan_done;
		logic eval_done;
		logic last_q;
		logic out_free;
	} kpm_sts_t;

	// Number of leading blanks of an entry, limited to the element width.
	function automatic logic [WCNT_W-1:0] lead_blanks(input logic [MAX_WIDTH-1:0] mask,
		input logic [WCNT_W-1:0] w);
		logic [WCNT_W-1:0] n;
		logic              run;
		n   = '0;
		run = 1'b1;
		for (int i = 0; i < MAX_WIDTH; i++) begin
			if (run && (WCNT_W'(i) < w) && mask[i]) begin
				n = n + WCNT_W'(1);
			end else begin
				run = 1'b0;
			end
		end
		return n;
	endfunction

endpackage
`default_nettype wire

### sv/keyword_prefix_matcher_top.sv
// Top level of the keyword prefix matcher: controller plus datapath.
// Depends on kpm_pkg, kpm_ctrl and kpm_dp.
//
//   Channel | Handshake          | Payload
//   --------+--------------------+----------------------------------------
//   in      | in_valid/in_stall  | in_item: func, entry, position, char, last
//   out     | out_valid/out_stall| out_item: status, match_index
//   cfg     | cfg_we             | cfg_index, cfg_data (write only)
//
// A load item is taken without leaving the idle state. A query character
// that is compared starts a scan that visits all sixteen table entries,
// with a keyword memory read for each entry still alive that fits, and
// then drains the compare stage. Whitespace, terminators and ignored
// characters are taken in the idle state. The item that carries last adds a
// result pass over the effective entry count (entry_count capped at sixteen).
// Reset is asynchronous and active low; the keyword memory is not cleared.
// A finished result waits in the output register while the block takes new
// items; only a second result has to wait for out_stall to drop.
`default_nettype none
module keyword_prefix_matcher_top import kpm_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire kpm_in_t               in_item,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output kpm_out_t                   out_item,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	kpm_cmd_t cmd;
	kpm_sts_t sts;

	// The controller sequences each item: load, per-entry scan, result pass.
	kpm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// The datapath holds the table, the query state and the result register.
	kpm_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_item   (in_item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

endmodule
`default_nettype wire

### sv/kpm_ctrl.sv
// Controller state machine of the keyword prefix matcher.
// Depends on kpm_pkg for the command and status structs.
`default_nettype none
module kpm_ctrl import kpm_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_stall,
	input  wire kpm_sts_t sts,
	output kpm_cmd_t      cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_EVAL = 2'd2;
	localparam logic [1:0] S_POST = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (!sts.is_query) begin
						cmd.load = 1'b1;
					end else begin
						cmd.query = 1'b1;
						if (sts.need_cmp) begin
							state_d = S_SCAN;
						end else if (sts.is_last) begin
							state_d = S_EVAL;
						end
					end
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_done) begin
					state_d = sts.last_q ? S_EVAL : S_IDLE;
				end
			end
			S_EVAL: begin
				cmd.eval = 1'b1;
				if (sts.eval_done) begin
					state_d = S_POST;
				end
			end
			S_POST: begin
				if (sts.out_free) begin
					cmd.publish = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

### sv/kpm_dp.sv
// Datapath of the keyword prefix matcher: keyword memory, blank masks,
// query state, entry scan and result register. Depends on kpm_pkg.
`default_nettype none
module kpm_dp import kpm_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire kpm_cmd_t              cmd,
	output kpm_sts_t                   sts,
	input  wire kpm_in_t               in_item,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output kpm_out_t                   out_item
);

	// Configuration registers.
	logic [CFG_DATA_W-1:0] count_q;
	logic [CFG_DATA_W-1:0] width_q;
	logic [WCNT_W-1:0]     w_eff;
	logic [CNT_W-1:0]      n_eff;

	// Keyword memory and per-entry blank masks.
	logic [7:0]           mem [MEM_DEPTH];
	logic [7:0]           rd_s1;
	logic [MAX_WIDTH-1:0] blank_q [MAX_ENTRIES];

	// Query state.
	logic [MAX_ENTRIES-1:0] alive_q;
	logic [MAX_ENTRIES-1:0] alive_d;
	logic [QLEN_W-1:0]      qlen_q;
	logic                   started_q;
	logic                   ended_q;
	logic [7:0]             char_q;
	logic                   last_q;

	// Scan and evaluation.
	logic [CNT_W-1:0] cnt_q;
	logic             pend_s1;
	logic [ENT_W-1:0] ent_s1;
	logic             exact_q;
	logic [ENT_W-1:0] found_q;
	logic [1:0]       acnt_q;

	logic [ENT_W-1:0]  cur_ent;
	logic [WCNT_W-1:0] cur_lead;
	logic [SUM_W-1:0]  cur_pos;
	logic              cnt_in_scan;
	logic              issue;
	logic              fits;
	logic              in_ws;
	logic              in_term;
	logic              eval_hit;
	logic              eval_exact;

	logic out_valid_q;

	always_comb begin
		if (width_q == '0) begin
			w_eff = WCNT_W'(1);
		end else if (WCNT_W'(width_q) > WCNT_W'(MAX_WIDTH) || width_q > CFG_DATA_W'(MAX_WIDTH)) begin
			w_eff = WCNT_W'(MAX_WIDTH);
		end else begin
			w_eff = WCNT_W'(width_q);
		end
		if (count_q > CFG_DATA_W'(MAX_ENTRIES)) begin
			n_eff = CNT_W'(MAX_ENTRIES);
		end else begin
			n_eff = CNT_W'(count_q);
		end
	end

	// Character classes of the incoming query character.
	assign in_ws   = (in_item.char_value == CH_SPACE) ||
		((in_item.char_value >= CH_TAB) && (in_item.char_value <= CH_CR));
	assign in_term = (in_item.char_value == CH_SPACE) || (in_item.char_value == CH_NUL);

	// Current entry under the counter and where the word lands in it.
	assign cur_ent     = cnt_q[ENT_W-1:0];
	assign cur_lead    = lead_blanks(blank_q[cur_ent], w_eff);
	assign cur_pos     = SUM_W'(cur_lead) + SUM_W'(qlen_q);
	assign fits        = cur_pos < SUM_W'(w_eff);
	assign cnt_in_scan = cnt_q < CNT_W'(MAX_ENTRIES);
	assign issue       = cmd.scan && cnt_in_scan && alive_q[cur_ent] && fits;

	assign eval_hit   = cmd.eval && (cnt_q < n_eff) && !exact_q && alive_q[cur_ent];
	assign eval_exact = cur_pos == SUM_W'(w_eff);

	always_comb begin
		sts.is_query  = (in_item.func == FN_QUERY);
		sts.is_last   = in_item.last;
		sts.need_cmp  = !ended_q && !(!started_q && in_ws) && !in_term;
		sts.scan_done = !cnt_in_scan && !pend_s1;
		sts.eval_done = cnt_q >= n_eff;
		sts.last_q    = last_q;
		sts.out_free  = !out_valid_q || !out_stall;
	end

	// An entry dies when the word runs past its end or the character differs.
	always_comb begin
		alive_d = alive_q;
		if (cmd.scan && cnt_in_scan && !fits) begin
			alive_d[cur_ent] = 1'b0;
		end
		if (pend_s1 && (rd_s1 != char_q)) begin
			alive_d[ent_s1] = 1'b0;
		end
	end

	// Keyword memory: written by load items, read at most once per entry during a scan.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mem[{in_item.entry[ENT_W-1:0], in_item.position[POS_W-1:0]}] <= in_item.char_value;
		end
		if (issue) begin
			rd_s1 <= mem[{cur_ent, cur_pos[POS_W-1:0]}];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= RST_ENTRY_COUNT;
			width_q   <= RST_ELEMENT_WIDTH;
			for (int i = 0; i < MAX_ENTRIES; i++) begin
				blank_q[i] <= '0;
			end
			alive_q     <= '1;
			qlen_q      <= '0;
			started_q   <= 1'b0;
			ended_q     <= 1'b0;
			last_q      <= 1'b0;
			cnt_q       <= '0;
			pend_s1     <= 1'b0;
			exact_q     <= 1'b0;
			acnt_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_ENTRY_COUNT) begin
					count_q <= cfg_data;
				end else if (cfg_index == CFG_ELEMENT_WIDTH) begin
					width_q <= cfg_data;
				end
			end

			if (cmd.load) begin
				blank_q[in_item.entry[ENT_W-1:0]][in_item.position[POS_W-1:0]] <=
					(in_item.char_value == CH_SPACE);
			end

			if (cmd.query) begin
				last_q  <= in_item.last;
				cnt_q   <= '0;
				exact_q <= 1'b0;
				acnt_q  <= '0;
				if (!ended_q) begin
					if (started_q || !in_ws) begin
						started_q <= 1'b1;
					end
					if ((started_q || !in_ws) && in_term) begin
						ended_q <= 1'b1;
					end
				end
			end

			if (cmd.scan) begin
				alive_q <= alive_d;
				pend_s1 <= issue;
				if (cnt_in_scan) begin
					cnt_q <= cnt_q + CNT_W'(1);
				end else if (!pend_s1) begin
					cnt_q <= '0;
					if (qlen_q != '1) begin
						qlen_q <= qlen_q + QLEN_W'(1);
					end
				end
			end

			if (cmd.eval && (cnt_q < n_eff)) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (eval_hit) begin
					if (eval_exact) begin
						exact_q <= 1'b1;
					end else if (acnt_q != 2'd2) begin
						acnt_q <= acnt_q + 2'd1;
					end
				end
			end

			if (cmd.publish) begin
				out_valid_q <= 1'b1;
				alive_q     <= '1;
				qlen_q      <= '0;
				started_q   <= 1'b0;
				ended_q     <= 1'b0;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers without reset.
	always_ff @(posedge clk) begin
		if (cmd.query) begin
			char_q <= in_item.char_value;
		end
		if (issue) begin
			ent_s1 <= cur_ent;
		end
		if (eval_hit && (eval_exact || acnt_q == 2'd0)) begin
			found_q <= cur_ent;
		end
		if (cmd.publish) begin
			priority if (exact_q) begin
				out_item.status      <= ST_EXACT;
				out_item.match_index <= 4'(found_q);
			end else if (acnt_q == 2'd1) begin
				out_item.status      <= ST_PREFIX;
				out_item.match_index <= 4'(found_q);
			end else if (acnt_q == 2'd0) begin
				out_item.status      <= ST_NONE;
				out_item.match_index <= '0;
			end else begin
				out_item.status      <= ST_AMBIG;
				out_item.match_index <= '0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

### sv/kpm_checker.sv
// Port-level checker for the keyword prefix matcher and its bind statement.
// Depends on kpm_pkg and keyword_prefix_matcher_top.
`default_nettype none
module kpm_checker import kpm_pkg::*; (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  in_valid,
	input wire logic                  in_stall,
	input wire kpm_in_t               in_item,
	input wire logic                  out_valid,
	input wire logic                  out_stall,
	input wire kpm_out_t              out_item
);

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_item))
		else $error("result changed while stalled");

	// Failed queries report index zero.
	a_fail_index: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_item.status == ST_NONE || out_item.status == ST_AMBIG)
		|-> out_item.match_index == '0)
		else $error("failed query reports a nonzero index");

	// The last query item always starts a result pass.
	a_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && in_item.func == FN_QUERY && in_item.last |=> in_stall)
		else $error("no result pass after last item");

	// A load item does not hold the input.
	a_load_fast: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && in_item.func == FN_LOAD |=> !in_stall)
		else $error("load item held the input");

	// A new result appears only at the end of a busy period.
	a_result_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without a result pass");

endmodule

bind keyword_prefix_matcher_top kpm_checker u_kpm_checker (.*);
`default_nettype wire

### bench/keyword_prefix_matcher_top_tb.sv
// Self-checking testbench for keyword_prefix_matcher_top: loads keyword tables,
// streams queries and checks every result against an in-bench prediction.
// Depends on kpm_pkg and the keyword_prefix_matcher_top RTL.
module keyword_prefix_matcher_top_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import kpm_pkg::*;

	// Cycles a query character plus the result pass can still need after the
	// last item was taken; used before register writes and at the end.
	localparam int SETTLE_CYCLES    = 64;
	// Length of the long output hold-off that backs the block up.
	localparam int HOLD_CYCLES      = 400;
	// Random items per register setting, on top of the table reload.
	localparam int RANDOM_PER_PHASE = 200;
	localparam int NUM_PHASES       = 6;

	// First letter of the small keyword alphabet; a small alphabet makes
	// shared prefixes and duplicate keywords common.
	localparam logic [7:0] CH_LOW_A = 8'h61;

	// Register indexes that the block has no register for.
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = CFG_IDX_W'(3);

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  in_valid  = 1'b0;
	logic                  in_stall;
	kpm_in_t               in_item   = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	kpm_out_t              out_item;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	keyword_prefix_matcher_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #4 clk = ~clk;

	// Bench-side copy of the block's state, updated item by item as items
	// are accepted.
	logic [7:0]             kw_table [MAX_ENTRIES][MAX_WIDTH];
	logic [MAX_ENTRIES-1:0] word_alive   = '1;
	int unsigned            word_len     = 0;
	bit                     word_started = 1'b0;
	bit                     word_ended   = 1'b0;
	logic [CFG_DATA_W-1:0]  reg_count    = RST_ENTRY_COUNT;
	logic [CFG_DATA_W-1:0]  reg_width    = RST_ELEMENT_WIDTH;

	// Items waiting to be offered, and match results waiting to come out.
	kpm_in_t  pending_items [$];
	kpm_out_t expected_results [$];

	int unsigned items_queued   = 0;
	int unsigned items_accepted = 0;
	int unsigned results_checked = 0;
	int unsigned error_count    = 0;

	// Idle rates in percent, the phase number and the long hold-off.
	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	int          phase_no      = -1;
	int unsigned pressure_mark = 32'hffff_ffff;
	logic        hold_off      = 1'b0;

	// Keywords the stimulus side believes are in the table, used to build
	// queries that hit, nearly hit or overrun a real entry.
	logic [7:0]  gen_word [MAX_ENTRIES][MAX_WIDTH];
	int unsigned gen_len  [MAX_ENTRIES];

	// Register values for each random phase. The extremes are here: no
	// entries, more entries than the table holds, width zero (acts as one)
	// and widths above the table width.
	logic [CFG_DATA_W-1:0] phase_counts [NUM_PHASES] = '{16, 31, 0, 7, 16, 12};
	logic [CFG_DATA_W-1:0] phase_widths [NUM_PHASES] = '{8, 16, 5, 0, 31, 1};

	// Directed table: two identical keywords, a longer keyword that shares
	// their prefix, a sibling and an all-blank entry.
	string directed_kw [5] = '{"     abc", "   abcde", "     abd", "        ", "     abc"};

	function automatic int unsigned active_width();
		int unsigned w;
		w = reg_width;
		if (w == 0) w = 1;
		if (w > MAX_WIDTH) w = MAX_WIDTH;
		return w;
	endfunction

	function automatic int unsigned active_count();
		return (reg_count > MAX_ENTRIES) ? MAX_ENTRIES : reg_count;
	endfunction

	// Leading blanks of a table entry, never counting past the width.
	function automatic int unsigned blank_run(int unsigned e, int unsigned w);
		int unsigned n;
		n = 0;
		while (n < w && kw_table[e][n] == CH_SPACE) n++;
		return n;
	endfunction

	// Compare one word character against every entry still in the race.
	// The compare position never leaves the entry: running off its end
	// kills the entry.
	function automatic void advance_word(logic [7:0] c);
		int unsigned w;
		int unsigned p;
		w = active_width();
		for (int e = 0; e < MAX_ENTRIES; e++) begin
			if (word_alive[e]) begin
				p = blank_run(e, w) + word_len;
				if (p >= w) begin
					word_alive[e] = 1'b0;
				end else if (kw_table[e][p] != c) begin
					word_alive[e] = 1'b0;
				end
			end
		end
		if (word_len < 31) word_len++;
	endfunction

	// Apply one accepted item to the bench state and, when it is a query
	// item that carries last, queue the match result it must produce.
	function automatic void predict_match(kpm_in_t it);
		bit          is_blank;
		bit          exact;
		int unsigned w;
		int unsigned n;
		int unsigned hits;
		int unsigned first;
		kpm_out_t    res;
		if (it.func == FN_LOAD) begin
			kw_table[it.entry][it.position] = it.char_value;
			return;
		end
		is_blank = (it.char_value == CH_SPACE) ||
			(it.char_value >= CH_TAB && it.char_value <= CH_CR);
		if (!word_ended && (word_started || !is_blank)) begin
			word_started = 1'b1;
			if (it.char_value == CH_SPACE || it.char_value == CH_NUL) begin
				word_ended = 1'b1;
			end else begin
				advance_word(it.char_value);
			end
		end
		if (!it.last) return;
		w     = active_width();
		n     = active_count();
		exact = 1'b0;
		hits  = 0;
		first = 0;
		for (int e = 0; e < n; e++) begin
			if (word_alive[e] && !exact) begin
				if (blank_run(e, w) + word_len == w) begin
					exact = 1'b1;
					first = e;
				end else begin
					if (hits == 0) first = e;
					hits++;
				end
			end
		end
		if (exact) begin
			res.status      = ST_EXACT;
			res.match_index = 4'(first);
		end else if (hits == 1) begin
			res.status      = ST_PREFIX;
			res.match_index = 4'(first);
		end else begin
			res.status      = (hits == 0) ? ST_NONE : ST_AMBIG;
			res.match_index = '0;
		end
		expected_results.push_back(res);
		word_alive   = '1;
		word_len     = 0;
		word_started = 1'b0;
		word_ended   = 1'b0;
	endfunction

	// Input driver. A new item is picked only when the slot is free or the
	// current item is taken this edge, so a stalled item never changes.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				predict_match(in_item);
				items_accepted++;
			end
			if (!in_valid || !in_stall) begin
				if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					in_item  <= pending_items.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Output monitor. Every result taken is checked against the oldest
	// prediction, field by field. The stall for the next cycle is random,
	// or forced high during the long hold-off.
	always @(posedge clk or negedge arst_n) begin : result_monitor
		kpm_out_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					error_count++;
					$display("%0t: unexpected result, expected none, actual status %0d index %0d",
						$time, out_item.status, out_item.match_index);
				end else begin
					want = expected_results.pop_front();
					results_checked++;
					if (out_item.status !== want.status) begin
						error_count++;
						$display("%0t: status mismatch, expected %0d, actual %0d",
							$time, want.status, out_item.status);
					end
					if (out_item.match_index !== want.match_index) begin
						error_count++;
						$display("%0t: match_index mismatch, expected %0d, actual %0d",
							$time, want.match_index, out_item.match_index);
					end
				end
			end
			out_stall <= hold_off || ($urandom_range(0, 99) < recv_idle_pct);
		end
	end

	// Long receiver hold-off during the second phase. The sender keeps
	// offering items, so finished results pile up in the block and it has
	// to stall its input.
	initial begin
		while (!(phase_no == 1 && items_accepted >= pressure_mark)) @(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	function automatic logic [7:0] pick_blank();
		int unsigned r;
		r = $urandom_range(0, 5);
		return (r == 5) ? CH_SPACE : CH_TAB + 8'(r);
	endfunction

	// Mostly the small alphabet, now and then a byte with the top bit set.
	function automatic logic [7:0] keyword_letter();
		if ($urandom_range(0, 9) == 0) return 8'($urandom_range(128, 255));
		return CH_LOW_A + 8'($urandom_range(0, 2));
	endfunction

	task automatic push_item(logic func, logic [3:0] ent, logic [3:0] pos,
		logic [7:0] ch, logic last);
		kpm_in_t it;
		it.func       = func;
		it.entry      = ent;
		it.position   = pos;
		it.char_value = ch;
		it.last       = last;
		pending_items.push_back(it);
		items_queued++;
	endtask

	// Query the characters of a string; entry and position are don't-care
	// on a query item and get random values.
	task automatic push_text(string s, bit last);
		for (int i = 0; i < s.len(); i++) begin
			push_item(FN_QUERY, 4'($urandom), 4'($urandom), s[i], last && i == s.len() - 1);
		end
	endtask

	// Registers are written only while the block is idle: every item taken,
	// every result out, and time for a trailing compare pass to finish.
	task automatic wait_idle();
		while (items_accepted != items_queued || expected_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_ENTRY_COUNT) begin
			reg_count = val;
		end else if (idx == CFG_ELEMENT_WIDTH) begin
			reg_width = val;
		end
	endtask

	// Fill every entry with a right-justified keyword for the current width.
	// Some entries repeat their neighbor or a prefix of it, so exact ties
	// and ambiguous prefixes show up; an empty keyword is an all-blank entry.
	// A few loads carry last, which must not produce a result.
	task automatic load_keyword_table();
		int unsigned w;
		int unsigned len;
		logic [7:0]  ch;
		w = active_width();
		for (int e = 0; e < MAX_ENTRIES; e++) begin
			if (e > 0 && $urandom_range(0, 3) == 0) begin
				len = gen_len[e - 1];
				for (int i = 0; i < MAX_WIDTH; i++) gen_word[e][i] = gen_word[e - 1][i];
				if (len > 0 && $urandom_range(0, 1) == 0) len--;
			end else begin
				len = $urandom_range(0, w);
				for (int i = 0; i < len; i++) gen_word[e][i] = keyword_letter();
			end
			gen_len[e] = len;
			for (int p = 0; p < w; p++) begin
				ch = (p < w - len) ? CH_SPACE : gen_word[e][p - (w - len)];
				push_item(FN_LOAD, 4'(e), 4'(p), ch, $urandom_range(0, 15) == 0);
			end
		end
	endtask

	// A well-formed query built from a table keyword: the whole keyword, a
	// prefix of it, or one letter too many. Optional leading blanks, an
	// optional terminator followed by characters that must be ignored, and
	// now and then a table load in the middle of the word.
	task automatic push_word_query();
		int unsigned e;
		int unsigned plen;
		int unsigned nws;
		int unsigned njunk;
		logic [7:0]  chars [$];
		e = $urandom_range(0, MAX_ENTRIES - 1);
		case ($urandom_range(0, 4))
			0, 1: plen = gen_len[e];
			2, 3: plen = $urandom_range(0, gen_len[e]);
			default: plen = gen_len[e] + 1;
		endcase
		nws = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
		for (int i = 0; i < nws; i++) chars.push_back(pick_blank());
		for (int i = 0; i < plen; i++) begin
			chars.push_back((i < gen_len[e]) ? gen_word[e][i] : keyword_letter());
		end
		if ($urandom_range(0, 1) == 0 || chars.size() == 0) begin
			chars.push_back($urandom_range(0, 1) ? CH_SPACE : CH_NUL);
			njunk = $urandom_range(0, 3);
			for (int i = 0; i < njunk; i++) chars.push_back(8'($urandom));
		end
		foreach (chars[i]) begin
			if ($urandom_range(0, 29) == 0) begin
				push_item(FN_LOAD, 4'($urandom), 4'($urandom), keyword_letter(), 1'b0);
			end
			push_item(FN_QUERY, 4'($urandom), 4'($urandom), chars[i], i == chars.size() - 1);
		end
	endtask

	// Noise: words of random bytes (some longer than the query counter
	// reaches), stray loads with random last, and blank-only queries.
	task automatic push_noise();
		int unsigned n;
		case ($urandom_range(0, 2))
			0: begin
				n = $urandom_range(1, 34);
				for (int i = 0; i < n; i++) begin
					push_item(FN_QUERY, 4'($urandom), 4'($urandom), 8'($urandom), i == n - 1);
				end
			end
			1: push_item(FN_LOAD, 4'($urandom), 4'($urandom), 8'($urandom), 1'($urandom));
			default: push_item(FN_QUERY, 4'($urandom), 4'($urandom), pick_blank(), 1'b1);
		endcase
	endtask

	// Main sequence.
	initial begin
		int unsigned target;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// The keyword memory is not cleared by reset, so every byte is
		// written before the first query can read it.
		send_idle_pct = 13;
		recv_idle_pct = 55;
		write_reg(CFG_ENTRY_COUNT, 5'd5);
		write_reg(CFG_ELEMENT_WIDTH, RST_ELEMENT_WIDTH);
		for (int e = 0; e < MAX_ENTRIES; e++) begin
			for (int p = 0; p < MAX_WIDTH; p++) begin
				push_item(FN_LOAD, 4'(e), 4'(p),
					(e < 5 && p < 8) ? directed_kw[e][p] : 8'($urandom), 1'b0);
			end
		end

		// Directed queries on the known table.
		push_text("abc", 1'b1);     // exact, the first of two equal entries wins
		push_text("\tabcd", 1'b1);  // leading blank skipped, unique prefix
		push_text("ab", 1'b1);      // several prefix matches: ambiguous
		push_text("abx", 1'b1);     // no entry matches
		push_text(" ", 1'b1);       // empty word: the all-blank entry is exact
		push_item(FN_QUERY, 4'($urandom), 4'($urandom), CH_NUL, 1'b1); // NUL ends an empty word
		push_text("abd", 1'b0);     // NUL ends the word, the rest is ignored
		push_item(FN_QUERY, 4'($urandom), 4'($urandom), CH_NUL, 1'b0);
		push_text("z", 1'b1);
		push_text("abcdef", 1'b1);  // runs past the end of the longest entry
		push_item(FN_LOAD, 4'd7, 4'd15, 8'hff, 1'b1); // last on a load: no result

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			wait_idle();
			if (ph == 1) pressure_mark = items_queued + 300;
			phase_no = ph;
			// Sender lightly idle and receiver heavily idle, then the other
			// way round, then full rate on both sides.
			if (ph < 2) begin
				send_idle_pct = 13;
				recv_idle_pct = 55;
			end else if (ph < 4) begin
				send_idle_pct = 55;
				recv_idle_pct = 13;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			write_reg(CFG_ENTRY_COUNT, phase_counts[ph]);
			write_reg(CFG_ELEMENT_WIDTH, phase_widths[ph]);
			if (ph == 2) begin
				write_reg(CFG_SPARE_LO, 5'($urandom));
				write_reg(CFG_SPARE_HI, '1);
			end
			load_keyword_table();
			target = items_queued + RANDOM_PER_PHASE;
			while (items_queued < target) begin
				if ($urandom_range(0, 4) != 0) begin
					push_word_query();
				end else begin
					push_noise();
				end
			end
			// Leave a word half typed in some phases, so the next register
			// writes and table reload land in the middle of a query.
			if (ph == 1 || ph == 3) begin
				push_item(FN_QUERY, 4'($urandom), 4'($urandom), keyword_letter(), 1'b0);
				push_item(FN_QUERY, 4'($urandom), 4'($urandom), keyword_letter(), 1'b0);
			end
		end
		wait_idle();

		$display("Run covered %0d items and %0d checked match results over %0d register settings,",
			items_accepted, results_checked, NUM_PHASES + 1);
		$display("including table reloads, queries spanning setting changes and a long output hold-off.");
		if (error_count == 0) begin
			$display("[keyword_prefix_matcher_top] OK");
		end else begin
			$display("[keyword_prefix_matcher_top] ERROR");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin
		#20ms;
		$display("[keyword_prefix_matcher_top] ERROR");
		$finish;
	end

endmodule

### filelist.f
sv/kpm_pkg.sv
sv/kpm_ctrl.sv
sv/kpm_dp.sv
sv/keyword_prefix_matcher_top.sv
sv/kpm_checker.sv
bench/keyword_prefix_matcher_top_tb.sv
